[src/c2s_pkg.sv]
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants and types for the cube-to-sphere point mapper.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int FIELD_W   = 16;
  localparam int FRAC_BITS = 14;
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int UNIT_I    = 1 << FRAC_BITS;
  localparam logic [MAG_W-1:0] UNIT = MAG_W'(UNIT_I);

  // floor(v / 3) as (v * DIV3_RECIP) >> DIV_SHIFT, exact for v <= UNIT
  localparam int DIV_SHIFT = MAG_W + 2;
  localparam logic [MAG_W:0] DIV3_RECIP =
    (MAG_W+1)'(((64'd1 << DIV_SHIFT) / 64'd3) + 64'd1);

  // digit-by-digit square root of arg << FRAC_BITS
  localparam int ROOT_W = MAG_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int CUR_W  = ROOT_W + 3;

  localparam int LANE_DEPTH = 4 + ROOT_W;
  localparam int PIPE_DEPTH = 1 + LANE_DEPTH;

  typedef struct packed {
    logic signed [FIELD_W-1:0] cube_x;
    logic signed [FIELD_W-1:0] cube_y;
    logic signed [FIELD_W-1:0] cube_z;
  } cube_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] sphere_x;
    logic signed [FIELD_W-1:0] sphere_y;
    logic signed [FIELD_W-1:0] sphere_z;
  } sphere_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] sq;
  } coord_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } lane_res_t;

endpackage

[src/c2s_front.sv]
// ----------------------------------------------------------------------------
// c2s_front
// Clamps the three cube coordinates to +-1.0 and registers sign, magnitude
// and floored square of each.
// ----------------------------------------------------------------------------
module c2s_front (
  input  logic                clk,
  input  logic                adv,
  input  c2s_pkg::cube_t      cube,
  output c2s_pkg::coord_t [2:0] coord
);

  logic signed [c2s_pkg::FIELD_W-1:0] raw  [3];
  c2s_pkg::coord_t                    comb [3];

  assign raw[0] = cube.cube_x;
  assign raw[1] = cube.cube_y;
  assign raw[2] = cube.cube_z;

  always_comb begin
    int                              sv;
    int                              lim;
    logic [c2s_pkg::MAG_W-1:0]       m;
    logic [2*c2s_pkg::MAG_W-1:0]     p;
    for (int i = 0; i < 3; i++) begin
      sv = int'(raw[i]);
      if (sv > c2s_pkg::UNIT_I) begin
        lim = c2s_pkg::UNIT_I;
      end else if (sv < -c2s_pkg::UNIT_I) begin
        lim = -c2s_pkg::UNIT_I;
      end else begin
        lim = sv;
      end
      m = (lim < 0) ? c2s_pkg::MAG_W'(-lim) : c2s_pkg::MAG_W'(lim);
      p = (2*c2s_pkg::MAG_W)'(m) * (2*c2s_pkg::MAG_W)'(m);
      comb[i].neg = (lim < 0);
      comb[i].mag = m;
      comb[i].sq  = p[c2s_pkg::FRAC_BITS +: c2s_pkg::MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        coord[i] <= comb[i];
      end
    end
  end

endmodule

[src/c2s_lane.sv]
// ----------------------------------------------------------------------------
// c2s_lane
// One coordinate lane: builds the root argument from the other two squares,
// takes its square root one bit per stage and scales the magnitude.
// ----------------------------------------------------------------------------
module c2s_lane (
  input  logic                          clk,
  input  logic                          adv,
  input  logic                          neg,
  input  logic [c2s_pkg::MAG_W-1:0]     mag,
  input  logic [c2s_pkg::MAG_W-1:0]     a2,
  input  logic [c2s_pkg::MAG_W-1:0]     b2,
  output c2s_pkg::lane_res_t            res
);

  localparam int MW = c2s_pkg::MAG_W;
  localparam int RW = c2s_pkg::ROOT_W;
  localparam int FB = c2s_pkg::FRAC_BITS;

  logic [2*MW-1:0] ab;
  logic [2*MW:0]   qm;

  logic [MW-1:0] prod1, half1, mag1;
  logic          neg1;
  logic [MW-1:0] q2, half2, mag2;
  logic          neg2;
  logic [MW-1:0] arg3, mag3;
  logic          neg3;

  logic [c2s_pkg::REM_W-1:0] rem  [RW];
  logic [c2s_pkg::RAD_W-1:0] rad  [RW];
  logic [RW-1:0]             root [RW+1];
  logic [MW-1:0]             magp [RW+1];
  logic                      negp [RW+1];

  logic [2*MW-1:0] scaled;

  assign ab = (2*MW)'(a2) * (2*MW)'(b2);
  assign qm = (2*MW+1)'(prod1) * (2*MW+1)'(c2s_pkg::DIV3_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1 <= ab[FB +: MW];
      half1 <= c2s_pkg::UNIT - (a2 >> 1) - (b2 >> 1);
      mag1  <= mag;
      neg1  <= neg;
      q2    <= MW'(qm[2*MW:c2s_pkg::DIV_SHIFT]);
      half2 <= half1;
      mag2  <= mag1;
      neg2  <= neg1;
      arg3  <= half2 + q2;
      mag3  <= mag2;
      neg3  <= neg2;
    end
  end

  assign rem[0]  = '0;
  assign rad[0]  = {1'b0, arg3, FB'(0)};
  assign root[0] = '0;
  assign magp[0] = mag3;
  assign negp[0] = neg3;

  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [c2s_pkg::CUR_W-1:0] cur;
    logic [c2s_pkg::CUR_W-1:0] trial;
    logic                      ge;

    assign cur   = {rem[k], rad[k][c2s_pkg::RAD_W-1 -: 2]};
    assign trial = c2s_pkg::CUR_W'({root[k], 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        root[k+1] <= {root[k][RW-2:0], ge};
        magp[k+1] <= magp[k];
        negp[k+1] <= negp[k];
      end
    end

    if (k < RW - 1) begin : g_carry
      logic [c2s_pkg::CUR_W-1:0] diff;
      assign diff = cur - trial;
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k+1] <= ge ? diff[c2s_pkg::REM_W-1:0] : cur[c2s_pkg::REM_W-1:0];
          rad[k+1] <= rad[k] << 2;
        end
      end
    end
  end

  assign scaled = (2*MW)'(magp[RW]) * (2*MW)'(root[RW]);

  always_ff @(posedge clk) begin
    if (adv) begin
      res.mag <= scaled[FB +: MW];
      res.neg <= negp[RW];
    end
  end

endmodule

[src/c2s_merge.sv]
// ----------------------------------------------------------------------------
// c2s_merge
// Joins the three lane results into one sphere point, applies the signs and
// holds it in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module c2s_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          last_valid,
  input  c2s_pkg::lane_res_t [2:0]      lane,
  output logic                          adv,
  output logic                          sphere_valid,
  input  logic                          sphere_ready,
  output c2s_pkg::sphere_t              sphere
);

  logic signed [c2s_pkg::FIELD_W-1:0] val [3];
  c2s_pkg::sphere_t                   point;
  c2s_pkg::sphere_t                   skid;
  logic                               skid_valid;
  logic                               push;
  logic                               out_free;

  always_comb begin
    logic [c2s_pkg::FIELD_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      m      = c2s_pkg::FIELD_W'(lane[i].mag);
      val[i] = lane[i].neg ? -m : m;
    end
  end

  assign point.sphere_x = val[0];
  assign point.sphere_y = val[1];
  assign point.sphere_z = val[2];

  assign adv      = !skid_valid;
  assign push     = adv && last_valid;
  assign out_free = !sphere_valid || sphere_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        sphere_valid <= skid_valid || push;
        skid_valid   <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      sphere <= skid_valid ? skid : point;
    end
    if (!out_free && push) begin
      skid <= point;
    end
  end

endmodule

[src/cube_to_sphere_map_core.sv]
// ----------------------------------------------------------------------------
// cube_to_sphere_map_core
// Maps a point on the unit cube onto the unit sphere, one point per cycle while not stalled.
// ----------------------------------------------------------------------------
// Takes one point per clock while not stalled. The clamp and squaring
// register loads at the transfer on cube; then come the root argument
// registers (product and half-sum, quotient, argument), the square root
// stages (one result bit per stage, the longest part of the path), the
// scaling register and the output register. Three identical lanes compute
// x, y and z side by side. The pipeline stalls only when both the output
// register and its skid register hold a point.
module cube_to_sphere_map_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cube_valid,
  output logic             cube_ready,
  input  c2s_pkg::cube_t   cube,
  output logic             sphere_valid,
  input  logic             sphere_ready,
  output c2s_pkg::sphere_t sphere
);

  logic                             adv;
  logic [c2s_pkg::PIPE_DEPTH-1:0]   vld;
  c2s_pkg::coord_t [2:0]            coord;
  c2s_pkg::lane_res_t [2:0]         lane;

  assign cube_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[c2s_pkg::PIPE_DEPTH-2:0], cube_valid};
    end
  end

  c2s_front u_front (
    .clk   (clk),
    .adv   (adv),
    .cube  (cube),
    .coord (coord)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    c2s_lane u_lane (
      .clk (clk),
      .adv (adv),
      .neg (coord[i].neg),
      .mag (coord[i].mag),
      .a2  (coord[(i+1)%3].sq),
      .b2  (coord[(i+2)%3].sq),
      .res (lane[i])
    );
  end

  c2s_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .last_valid   (vld[c2s_pkg::PIPE_DEPTH-1]),
    .lane         (lane),
    .adv          (adv),
    .sphere_valid (sphere_valid),
    .sphere_ready (sphere_ready),
    .sphere       (sphere)
  );

endmodule

[src/c2s_checker.sv]
// ----------------------------------------------------------------------------
// c2s_checker
// Port-level checks for the cube-to-sphere mapper.
// ----------------------------------------------------------------------------
module c2s_checker (
  input logic             clk,
  input logic             rst,
  input logic             cube_ready,
  input logic             sphere_valid,
  input logic             sphere_ready,
  input c2s_pkg::sphere_t sphere
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    sphere_valid && !sphere_ready |=> sphere_valid)
    else $error("sphere_valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    sphere_valid && !sphere_ready |=> $stable(sphere))
    else $error("sphere payload changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    sphere_valid |->
      int'(sphere.sphere_x) <= c2s_pkg::UNIT_I && int'(sphere.sphere_x) >= -c2s_pkg::UNIT_I &&
      int'(sphere.sphere_y) <= c2s_pkg::UNIT_I && int'(sphere.sphere_y) >= -c2s_pkg::UNIT_I &&
      int'(sphere.sphere_z) <= c2s_pkg::UNIT_I && int'(sphere.sphere_z) >= -c2s_pkg::UNIT_I)
    else $error("sphere coordinate beyond unit range");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !sphere_valid)
    else $error("sphere_valid set right after reset");

  a_reset_in: assert property (@(posedge clk)
    rst |=> cube_ready)
    else $error("cube_ready low right after reset");

endmodule

bind cube_to_sphere_map_core c2s_checker u_c2s_checker (.*);
